[rtl/lrsi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lrsi_pkg;
  localparam int KEY_W = 64;
  localparam int POS_W = 6;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [POS_W-1:0] original_position;
    logic             last_result;
    logic             keys_dropped;
  } out_item_t;
endpackage
`default_nettype wire

[rtl/lsd_radix_sort_with_index.sv]
`timescale 1ns / 1ps
`default_nettype none
// load: one key transfer per cycle; after the final key the input stalls until the set is out
// sort: each digit pass clears the count table, counts the digits, forms exclusive prefix sums,
//   scatters into the back store and copies back; at most KEY_BITS/DIGIT_BITS passes, rounded up
// emit: each result is read from the front store, then loaded into the output register; the
//   set closes once the last result has left; a stalled output register holds the sweep
// reset: synchronous rst clears control, fill count, largest key and the overflow flag;
//   key, position and count stores are not reset (counts are cleared before each pass)
module lsd_radix_sort_with_index #(
  parameter int MAX_ITEMS  = 64,
  parameter int DIGIT_BITS = 8,
  parameter int KEY_BITS   = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lrsi_pkg::in_item_t  in_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output lrsi_pkg::out_item_t     out_data,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = AW + 1;
  localparam int DV = 1 << DIGIT_BITS;
  localparam int KW = lrsi_pkg::KEY_W;
  localparam int PW = lrsi_pkg::POS_W;
  // sweep index covers both the key sweeps and the count table sweeps
  localparam int IW = ((CW > DIGIT_BITS) ? CW : DIGIT_BITS) + 1;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_CLR   = 8'b0000_0010,
    S_CNT   = 8'b0000_0100,
    S_PRE   = 8'b0000_1000,
    S_SCAT  = 8'b0001_0000,
    S_COPY  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_DRAIN = 8'b1000_0000
  } state_t;

  // key/position stores, front and back, and the digit count table
  logic [KW-1:0]      kf [MAX_ITEMS];
  logic [KW-1:0]      kb [MAX_ITEMS];
  logic [AW:0]        pf [MAX_ITEMS];
  logic [AW:0]        pb [MAX_ITEMS];
  logic [CW-1:0]      cnt [DV];

  state_t             state;
  logic [CW-1:0]      n;           // keys held
  logic [KW-1:0]      largest;
  logic               dropped;
  logic [6:0]         shift;
  logic [IW-1:0]      idx;         // sweep index
  logic [CW-1:0]      running;
  logic               rd_ok;       // read data below is valid for the current index
  logic [KW-1:0]      kf_q, kb_q;
  logic [AW:0]        pf_q, pb_q;
  logic [CW-1:0]      cnt_q;
  logic [DIGIT_BITS-1:0] dig_q;    // digit of the key behind cnt_q

  logic [KW-1:0] key_in;
  assign key_in = (KEY_BITS >= 64) ? in_data.key_value
                : (in_data.key_value & ((64'd1 << (KEY_BITS % 64)) - 64'd1));

  assign in_ready = (state == S_LOAD);

  logic [DIGIT_BITS-1:0] dig_f;
  assign dig_f = DIGIT_BITS'(kf_q >> shift);

  logic [6:0] shift_nx;
  assign shift_nx = shift + 7'(DIGIT_BITS);
  logic more;
  assign more = (32'(shift_nx) < KEY_BITS) && (shift_nx < 7'd64) &&
                ((largest >> shift_nx) != '0);

  logic idx_end_n;   // index reached n
  assign idx_end_n = (idx == IW'(n));

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      n         <= '0;
      largest   <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      rd_ok     <= 1'b0;
      shift     <= '0;
      running   <= '0;
    end else begin
      // a result leaving with no new one loaded behind it
      if (out_valid && out_ready && !(state == S_EMIT && rd_ok)) out_valid <= 1'b0;
      unique case (state)
        S_LOAD: if (in_valid) begin
          if (32'(n) < MAX_ITEMS) begin
            kf[n[AW-1:0]] <= key_in;
            pf[n[AW-1:0]] <= (AW+1)'(n);
            n <= n + 1'b1;
            if (key_in > largest) largest <= key_in;
          end else begin
            dropped <= 1'b1;
          end
          if (in_data.last_item) begin
            state <= S_CLR;
            idx   <= '0;
            shift <= '0;
          end
        end
        S_CLR: begin
          cnt[idx[DIGIT_BITS-1:0]] <= '0;
          if (32'(idx) == DV - 1) begin
            state <= S_CNT; idx <= '0; rd_ok <= 1'b0;
          end else idx <= idx + 1'b1;
        end
        S_CNT: begin
          // stage 1 reads the key, stage 2 reads the count, stage 3 writes it
          // back; two keys in flight with the same digit need forwarding, so
          // this sweep takes a new key only after the last count is written back
          case (running[1:0])
            2'd0: begin
              if (idx_end_n) begin
                state <= S_PRE; idx <= '0; running <= '0;
              end else begin
                kf_q <= kf[idx[AW-1:0]];
                running[1:0] <= 2'd1;
              end
            end
            2'd1: begin
              dig_q <= dig_f;
              cnt_q <= cnt[dig_f];
              running[1:0] <= 2'd2;
            end
            default: begin
              cnt[dig_q] <= cnt_q + 1'b1;
              idx <= idx + 1'b1;
              running[1:0] <= 2'd0;
            end
          endcase
        end
        S_PRE: begin
          // read count, then write exclusive prefix, for each entry in turn
          if (!rd_ok) begin
            cnt_q <= cnt[idx[DIGIT_BITS-1:0]];
            rd_ok <= 1'b1;
          end else begin
            cnt[idx[DIGIT_BITS-1:0]] <= running;
            rd_ok   <= 1'b0;
            if (32'(idx) == DV - 1) begin
              state <= S_SCAT; idx <= '0; running <= '0;
            end else begin
              running <= running + cnt_q;
              idx     <= idx + 1'b1;
            end
          end
        end
        S_SCAT: begin
          case (running[1:0])
            2'd0: begin
              if (idx_end_n) begin
                state <= S_COPY; idx <= '0; running <= '0;
              end else begin
                kf_q <= kf[idx[AW-1:0]];
                pf_q <= pf[idx[AW-1:0]];
                running[1:0] <= 2'd1;
              end
            end
            2'd1: begin
              dig_q <= dig_f;
              cnt_q <= cnt[dig_f];
              running[1:0] <= 2'd2;
            end
            default: begin
              cnt[dig_q] <= cnt_q + 1'b1;
              kb[cnt_q[AW-1:0]] <= kf_q;
              pb[cnt_q[AW-1:0]] <= pf_q;
              idx <= idx + 1'b1;
              running[1:0] <= 2'd0;
            end
          endcase
        end
        S_COPY: begin
          if (!rd_ok) begin
            if (idx_end_n) begin
              if (more) begin
                shift <= shift_nx; state <= S_CLR; idx <= '0;
              end else begin
                state <= S_EMIT; idx <= '0;
              end
            end else begin
              kb_q  <= kb[idx[AW-1:0]];
              pb_q  <= pb[idx[AW-1:0]];
              rd_ok <= 1'b1;
            end
          end else begin
            kf[idx[AW-1:0]] <= kb_q;
            pf[idx[AW-1:0]] <= pb_q;
            rd_ok <= 1'b0;
            idx   <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          // read one entry, then place it in the output register
          if (!rd_ok) begin
            if (idx_end_n) begin
              state <= S_DRAIN;
            end else begin
              kf_q  <= kf[idx[AW-1:0]];
              pf_q  <= pf[idx[AW-1:0]];
              rd_ok <= 1'b1;
            end
          end else if (out_free) begin
            out_valid <= 1'b1;
            out_data.sorted_key        <= kf_q;
            out_data.original_position <= PW'(pf_q);
            out_data.last_result       <= (idx[CW-1:0] + 1'b1 == n);
            out_data.keys_dropped      <= dropped;
            rd_ok <= 1'b0;
            idx   <= idx + 1'b1;
          end
        end
        S_DRAIN: begin
          // new set starts once the last result has left
          if (out_free) begin
            state   <= S_LOAD;
            n       <= '0;
            largest <= '0;
            dropped <= 1'b0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire
